// ===== hdl/ssr_pkg.sv =====
// ---------------------------------------------------------------------------
// ssr_pkg
// Shared types, constants and helpers for the stream substring replacer.
// ---------------------------------------------------------------------------
package ssr_pkg;

  // longest pattern and replacement held in the config registers
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  // entries in the request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // config register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  // byte position within a 64-bit pattern or replacement word
  localparam int POS_W = 3;

  // width of the count of results one source byte can cause
  localparam int TOTAL_W = 5;

  // live configuration, lengths already saturated
  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_len;
    logic [63:0] replacement_bytes;
    logic [3:0]  replacement_len;
  } cfg_t;

  // one request: what the back part must emit for one source byte
  typedef struct packed {
    logic [3:0]         head_len;     // withheld prefix bytes flushed first
    logic               mid_literal;  // middle run is the source byte itself
    logic [7:0]         literal;      // source byte
    logic [3:0]         mid_len;      // middle run length (literal or replacement)
    logic [3:0]         tail_len;     // prefix flushed on the final byte
    logic               last;         // end marker closes the run
    logic [TOTAL_W-1:0] total;        // results in this run
  } job_t;

  // clamp a 4-bit length to a limit
  function automatic logic [3:0] sat_len(input logic [3:0] len, input logic [3:0] limit);
    sat_len = (len > limit) ? limit : len;
  endfunction

  // pick byte i from a 64-bit word, byte 0 in the low bits
  function automatic logic [7:0] byte_sel(input logic [63:0] word, input logic [POS_W-1:0] i);
    byte_sel = word[{i, 3'b000} +: 8];
  endfunction

endpackage

// ===== hdl/stream_substring_replace.sv =====
// ---------------------------------------------------------------------------
// stream_substring_replace
// Streaming find-and-replace on a byte stream.
// ---------------------------------------------------------------------------
// Source bytes enter on the input channel (in_valid / in_stall) with
// final_byte marking the last byte of a text. Non-overlapping occurrences of
// the configured pattern are replaced by the configured replacement; after a
// mismatch the counter retries only the first pattern byte, so overlapping
// candidates may be missed. Bytes of a partial match are withheld until it
// resolves. Each result leaves on the output channel (out_valid / out_stall)
// with run_end on the last result caused by one source byte and text_end on
// the end marker that closes a text. A byte that only extends a match causes
// no result. Config is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data, always ready; the user must write it only while no request is
// in flight, which the block does not enforce. Throughput: one result per
// cycle while out_stall is low, set by the single output stage; a
// multi-result byte holds the output until its last is taken, and input
// bytes are taken every cycle while the 2-entry request queue has room. A
// stalled output holds its result; the queue then fills and in_stall rises.
// Reset clears the config registers, the match counter and the queue.
// ---------------------------------------------------------------------------
module stream_substring_replace import ssr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             source_byte,
  input  logic                   final_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   byte_valid,
  output logic                   run_end,
  output logic                   text_end,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [63:0] replacement_bytes;
  logic [3:0]  replacement_length;
  cfg_t        cfg;
  logic        push;
  job_t        push_job;
  logic        pop;
  job_t        head_job;
  logic        queue_full;
  logic        not_empty;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= '0;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // saturated view for front and back
  always_comb begin
    cfg.pattern_bytes     = pattern_bytes;
    cfg.pattern_len       = sat_len(pattern_length, 4'(MAX_PATTERN));
    cfg.replacement_bytes = replacement_bytes;
    cfg.replacement_len   = sat_len(replacement_length, 4'(MAX_REPLACEMENT));
  end

  ssr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .source_byte (source_byte),
    .final_byte  (final_byte),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  ssr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head_job  (head_job),
    .full      (queue_full),
    .not_empty (not_empty)
  );

  ssr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_job   (head_job),
    .not_empty  (not_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .run_end    (run_end),
    .text_end   (text_end)
  );

endmodule

// ===== hdl/ssr_front.sv =====
// ---------------------------------------------------------------------------
// ssr_front
// Accepts source bytes, tracks the match counter and turns each byte into
// a request describing the results it causes.
// ---------------------------------------------------------------------------
module ssr_front import ssr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] source_byte,
  input  logic       final_byte,
  input  logic       queue_full,
  output logic       push,
  output job_t       push_job
);

  logic [3:0] matched_count;
  logic [3:0] matched_count_next;
  logic       accept;
  logic       hit;
  logic       first_hit;
  logic       rep;
  logic [3:0] after_count;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // compare against the next pattern byte and against the first one
  assign hit = (matched_count < cfg.pattern_len) &&
               (source_byte == byte_sel(cfg.pattern_bytes, matched_count[POS_W-1:0]));
  assign first_hit = (cfg.pattern_len != 4'd0) &&
                     (source_byte == byte_sel(cfg.pattern_bytes, '0));

  // classify the byte
  always_comb begin
    rep                  = 1'b0;
    after_count          = 4'd0;
    push_job.head_len    = 4'd0;
    push_job.mid_literal = 1'b0;
    push_job.literal     = source_byte;
    if (hit) begin
      if (matched_count + 4'd1 == cfg.pattern_len) begin
        rep = 1'b1;
      end else begin
        after_count = matched_count + 4'd1;
      end
    end else begin
      push_job.head_len = sat_len(matched_count, 4'(MAX_PATTERN));
      if (first_hit) begin
        if (cfg.pattern_len == 4'd1) begin
          rep = 1'b1;
        end else begin
          after_count = 4'd1;
        end
      end else begin
        push_job.mid_literal = 1'b1;
      end
    end
    push_job.mid_len  = push_job.mid_literal ? 4'd1 : (rep ? cfg.replacement_len : 4'd0);
    push_job.tail_len = final_byte ? after_count : 4'd0;
    push_job.last     = final_byte;
    push_job.total    = TOTAL_W'(push_job.head_len) + TOTAL_W'(push_job.mid_len) +
                        TOTAL_W'(push_job.tail_len) + TOTAL_W'(final_byte);
    matched_count_next = final_byte ? 4'd0 : after_count;
  end

  // requests that cause no result never enter the queue
  assign push = accept && (push_job.total != '0);

  // match counter
  always_ff @(posedge clk) begin
    if (rst) begin
      matched_count <= 4'd0;
    end else if (accept) begin
      matched_count <= matched_count_next;
    end
  end

endmodule

// ===== hdl/ssr_queue.sv =====
// ---------------------------------------------------------------------------
// ssr_queue
// Short request queue that lets front and back stall independently.
// ---------------------------------------------------------------------------
module ssr_queue import ssr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic full,
  output logic not_empty
);

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t               mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full      = (count == COUNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_job  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/ssr_back.sv =====
// ---------------------------------------------------------------------------
// ssr_back
// Emits the results of queued requests one per cycle while out_stall is low.
// ---------------------------------------------------------------------------
module ssr_back import ssr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  job_t       head_job,
  input  logic       not_empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_end,
  output logic       text_end
);

  job_t               cur;
  logic               cur_valid;
  logic [TOTAL_W-1:0] pos;
  logic               out_accept;
  logic               is_last;
  logic [TOTAL_W-1:0] mid_start;
  logic [TOTAL_W-1:0] tail_start;
  logic [TOTAL_W-1:0] end_start;
  logic [TOTAL_W-1:0] mid_off;
  logic [TOTAL_W-1:0] tail_off;

  assign out_valid  = cur_valid;
  assign out_accept = cur_valid && !out_stall;
  assign is_last    = (pos == cur.total - 1'b1);
  assign run_end    = is_last;
  assign pop        = not_empty && (!cur_valid || (out_accept && is_last));

  // segment boundaries of the current run
  assign mid_start  = TOTAL_W'(cur.head_len);
  assign tail_start = mid_start + TOTAL_W'(cur.mid_len);
  assign end_start  = tail_start + TOTAL_W'(cur.tail_len);
  assign mid_off    = pos - mid_start;
  assign tail_off   = pos - tail_start;

  // pick the byte for the current position
  always_comb begin
    out_byte   = 8'd0;
    byte_valid = 1'b1;
    text_end   = 1'b0;
    priority if (pos < mid_start) begin
      out_byte = byte_sel(cfg.pattern_bytes, pos[POS_W-1:0]);
    end else if (pos < tail_start) begin
      out_byte = cur.mid_literal ? cur.literal :
                 byte_sel(cfg.replacement_bytes, mid_off[POS_W-1:0]);
    end else if (pos < end_start) begin
      out_byte = byte_sel(cfg.pattern_bytes, tail_off[POS_W-1:0]);
    end else begin
      byte_valid = 1'b0;
      text_end   = 1'b1;
    end
  end

  // current request and position within it
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= '0;
    end else if (pop) begin
      cur       <= head_job;
      cur_valid <= 1'b1;
      pos       <= '0;
    end else if (out_accept) begin
      if (is_last) begin
        cur_valid <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule
